>>> hw/rtl/sti_pkg.sv
// shared types, constants and state encodings for the sensor table interpolator
`timescale 1ns / 1ps
package sti_pkg;

  localparam int TABLE_DEPTH = 131072;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CFG_W       = 18;
  localparam int CHANNELS    = 9;
  localparam int GYRO_FIRST  = 6;
  localparam int DIV_STEPS   = 34;
  localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [16:0]        entry_index;
    logic [31:0]        sample_time;
    logic signed [31:0] vel_east_in;
    logic signed [31:0] vel_north_in;
    logic signed [31:0] vel_down_in;
    logic signed [31:0] acc_x_in;
    logic signed [31:0] acc_y_in;
    logic signed [31:0] acc_z_in;
    logic signed [31:0] rate_x_deg;
    logic signed [31:0] rate_y_deg;
    logic signed [31:0] rate_z_deg;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vel_east_out;
    logic signed [31:0] vel_north_out;
    logic signed [31:0] vel_down_out;
    logic signed [31:0] acc_x_out;
    logic signed [31:0] acc_y_out;
    logic signed [31:0] acc_z_out;
    logic signed [31:0] rate_x_rad;
    logic signed [31:0] rate_y_rad;
    logic signed [31:0] rate_z_rad;
    logic               exact_hit;
    logic               query_status;
  } out_item_t;

  // control from the search sequencer to every lane
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic              cap0;
    logic              start;
    logic              exact;
    logic              zero;
    logic              neg_t;
    logic [31:0]       dx_mag;
    logic [31:0]       dt_mag;
  } lane_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_CHK_FIRST, S_CHK_LAST, S_FIX, S_MID, S_CHK_MID,
    S_CH0, S_CH1, S_CH2, S_RUN
  } search_state_t;

  typedef enum logic [3:0] {
    L_IDLE, L_DV, L_MUL0, L_MUL1, L_NUM, L_CHK, L_DIV, L_ACC, L_RAD, L_RND
  } lane_state_t;

endpackage

>>> hw/rtl/sti_lane.sv
// one channel lane: record store plus interpolation, rounding and degree conversion
`timescale 1ns / 1ps
module sti_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  sti_pkg::lane_ctl_t ctl,
  input  logic signed [31:0] wr_data,
  input  logic               gyro,
  output logic               done,
  output logic signed [31:0] result
);
  import sti_pkg::*;

  logic signed [31:0] mem [TABLE_DEPTH];
  logic signed [31:0] rdata_r;

  lane_state_t state_r, state_nxt;
  logic signed [31:0] v0_r, v0_nxt, v1_r, v1_nxt, res_r, res_nxt;
  logic [32:0]  dvmag_r, dvmag_nxt;
  logic         neg_r, neg_nxt, sat_r, sat_nxt, done_r, done_nxt;
  logic [64:0]  prod_r, prod_nxt;
  logic [65:0]  num_r, num_nxt;
  logic [33:0]  sh_r, sh_nxt, q_r, q_nxt;
  logic [31:0]  rem_r, rem_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [57:0]  m_r, m_nxt;

  logic signed [32:0] dv;
  logic [32:0]  rem2;
  logic [33:0]  qe;
  logic signed [35:0] acc;
  logic [31:0]  res_mag;
  logic [25:0]  rnd;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) mem[ctl.addr] <= wr_data;
    if (ctl.rd_en) rdata_r <= mem[ctl.addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    v0_r <= v0_nxt; v1_r <= v1_nxt; res_r <= res_nxt;
    dvmag_r <= dvmag_nxt; neg_r <= neg_nxt; sat_r <= sat_nxt;
    prod_r <= prod_nxt; num_r <= num_nxt; sh_r <= sh_nxt; q_r <= q_nxt;
    rem_r <= rem_nxt; cnt_r <= cnt_nxt; m_r <= m_nxt;
  end

  always_comb begin
    state_nxt = state_r; done_nxt = done_r;
    v0_nxt = v0_r; v1_nxt = v1_r; res_nxt = res_r;
    dvmag_nxt = dvmag_r; neg_nxt = neg_r; sat_nxt = sat_r;
    prod_nxt = prod_r; num_nxt = num_r; sh_nxt = sh_r; q_nxt = q_r;
    rem_nxt = rem_r; cnt_nxt = cnt_r; m_nxt = m_r;
    dv      = 33'(v1_r) - 33'(v0_r);
    rem2    = {rem_r, sh_r[33]};
    qe      = sat_r ? 34'h2_0000_0000 : q_r;
    acc     = neg_r ? (36'(v0_r) - 36'(signed'({2'b00, qe})))
                    : (36'(v0_r) + 36'(signed'({2'b00, qe})));
    res_mag = res_r[31] ? 32'(-33'(res_r)) : 32'(res_r);
    rnd     = 26'((m_r + 58'h8000_0000) >> 32);
    if (ctl.cap0) v0_nxt = rdata_r;
    unique case (state_r)
      L_IDLE: begin
        if (ctl.start) begin
          v1_nxt   = rdata_r;
          done_nxt = 1'b0;
          if (ctl.exact || ctl.zero) begin
            res_nxt   = v0_r;
            state_nxt = L_RAD;
          end else begin
            state_nxt = L_DV;
          end
        end
      end
      L_DV: begin
        dvmag_nxt = dv[32] ? 33'(-dv) : 33'(dv);
        neg_nxt   = dv[32] ^ ctl.neg_t;
        state_nxt = L_MUL0;
      end
      L_MUL0: begin
        prod_nxt  = 65'(dvmag_r[15:0] * ctl.dx_mag);
        state_nxt = L_MUL1;
      end
      L_MUL1: begin
        prod_nxt  = prod_r + (65'(dvmag_r[32:16] * ctl.dx_mag) << 16);
        state_nxt = L_NUM;
      end
      L_NUM: begin
        num_nxt   = 66'(prod_r) + 66'(ctl.dt_mag >> 1);
        state_nxt = L_CHK;
      end
      L_CHK: begin
        sat_nxt   = num_r[65:34] >= ctl.dt_mag;
        rem_nxt   = num_r[65:34];
        sh_nxt    = num_r[33:0];
        q_nxt     = '0;
        cnt_nxt   = 6'(DIV_STEPS);
        state_nxt = L_DIV;
      end
      L_DIV: begin
        sh_nxt = {sh_r[32:0], 1'b0};
        if (rem2 >= {1'b0, ctl.dt_mag}) begin
          rem_nxt = 32'(rem2 - {1'b0, ctl.dt_mag});
          q_nxt   = {q_r[32:0], 1'b1};
        end else begin
          rem_nxt = rem2[31:0];
          q_nxt   = {q_r[32:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) state_nxt = L_ACC;
      end
      L_ACC: begin
        if (acc > 36'sd2147483647)       res_nxt = 32'h7fff_ffff;
        else if (acc < -36'sd2147483648) res_nxt = 32'h8000_0000;
        else                             res_nxt = acc[31:0];
        state_nxt = L_RAD;
      end
      L_RAD: begin
        if (gyro) begin
          m_nxt     = 58'(res_mag * DEG_TO_RAD_Q32);
          state_nxt = L_RND;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = L_IDLE;
        end
      end
      L_RND: begin
        res_nxt   = res_r[31] ? -32'(rnd) : 32'(rnd);
        done_nxt  = 1'b1;
        state_nxt = L_IDLE;
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

>>> hw/rtl/sti_search.sv
// timestamp store and binary search sequencer that drives the lanes
`timescale 1ns / 1ps
module sti_search (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  sti_pkg::in_item_t         in_item,
  input  logic [sti_pkg::CFG_W-1:0] entries,
  input  logic                      lanes_done,
  input  logic                      merge_free,
  output sti_pkg::lane_ctl_t        ctl,
  output logic                      merge_load,
  output logic                      exact,
  output logic                      outside
);
  import sti_pkg::*;

  logic [31:0] tmem [TABLE_DEPTH];
  logic [31:0] trd_r;
  logic        t_rd_en, t_wr_en;
  logic [ADDR_W-1:0] t_addr;

  search_state_t state_r, state_nxt;
  logic [31:0] tq_r, tq_nxt, tlo_r, tlo_nxt, thi_r, thi_nxt;
  logic [ADDR_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, hit_r, hit_nxt, mid;
  logic exact_r, exact_nxt, outside_r, outside_nxt, below_r, below_nxt;
  logic [CFG_W-1:0] n_clamp;
  logic signed [32:0] dx, dt;
  logic accept;

  always_ff @(posedge clk) begin
    if (t_wr_en) tmem[t_addr] <= in_item.sample_time;
    if (t_rd_en) trd_r <= tmem[t_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
    tq_r <= tq_nxt; tlo_r <= tlo_nxt; thi_r <= thi_nxt;
    lo_r <= lo_nxt; hi_r <= hi_nxt; hit_r <= hit_nxt;
    exact_r <= exact_nxt; outside_r <= outside_nxt; below_r <= below_nxt;
  end

  assign accept = in_valid && !in_stall;
  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign dx     = 33'(tq_r) - 33'(tlo_r);
  assign dt     = 33'(thi_r) - 33'(tlo_r);

  always_comb begin
    if (entries < CFG_W'(2))                n_clamp = CFG_W'(2);
    else if (entries > CFG_W'(TABLE_DEPTH)) n_clamp = CFG_W'(TABLE_DEPTH);
    else                                    n_clamp = entries;
  end

  always_comb begin
    state_nxt = state_r;
    tq_nxt = tq_r; tlo_nxt = tlo_r; thi_nxt = thi_r;
    lo_nxt = lo_r; hi_nxt = hi_r; hit_nxt = hit_r;
    exact_nxt = exact_r; outside_nxt = outside_r; below_nxt = below_r;
    t_rd_en = 1'b0; t_wr_en = 1'b0; t_addr = '0;
    merge_load = 1'b0;
    ctl = '0;
    ctl.exact  = exact_r;
    ctl.zero   = (thi_r == tlo_r);
    ctl.neg_t  = dx[32] ^ dt[32];
    ctl.dx_mag = dx[32] ? 32'(-dx) : 32'(dx);
    ctl.dt_mag = dt[32] ? 32'(-dt) : 32'(dt);
    unique case (state_r)
      S_IDLE: begin
        t_addr   = in_item.entry_index;
        ctl.addr = in_item.entry_index;
        if (accept) begin
          if (in_item.req_type == REQ_LOAD) begin
            t_wr_en    = 1'b1;
            ctl.wr_en  = 1'b1;
          end else begin
            tq_nxt      = in_item.sample_time;
            lo_nxt      = '0;
            hi_nxt      = ADDR_W'(n_clamp - CFG_W'(1));
            exact_nxt   = 1'b0;
            outside_nxt = 1'b0;
            state_nxt   = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        t_rd_en   = 1'b1;
        t_addr    = '0;
        state_nxt = S_CHK_FIRST;
      end
      S_CHK_FIRST: begin
        t_rd_en = 1'b1;
        t_addr  = hi_r;
        tlo_nxt = trd_r;
        if (trd_r == tq_r) begin
          exact_nxt = 1'b1;
          hit_nxt   = '0;
          state_nxt = S_CH0;
        end else begin
          state_nxt = S_CHK_LAST;
        end
      end
      S_CHK_LAST: begin
        if (trd_r == tq_r) begin
          exact_nxt = 1'b1;
          hit_nxt   = hi_r;
          state_nxt = S_CH0;
        end else if (tq_r < tlo_r) begin
          // below the first record: segment of records 0 and 1
          outside_nxt = 1'b1;
          below_nxt   = 1'b1;
          hi_nxt      = ADDR_W'(1);
          t_rd_en     = 1'b1;
          t_addr      = ADDR_W'(1);
          state_nxt   = S_FIX;
        end else if (tq_r > trd_r) begin
          outside_nxt = 1'b1;
          below_nxt   = 1'b0;
          lo_nxt      = hi_r - ADDR_W'(1);
          thi_nxt     = trd_r;
          t_rd_en     = 1'b1;
          t_addr      = hi_r - ADDR_W'(1);
          state_nxt   = S_FIX;
        end else begin
          thi_nxt   = trd_r;
          state_nxt = S_MID;
        end
      end
      S_FIX: begin
        if (below_r) thi_nxt = trd_r;
        else         tlo_nxt = trd_r;
        state_nxt = S_CH0;
      end
      S_MID: begin
        if (hi_r - lo_r > ADDR_W'(1)) begin
          t_rd_en   = 1'b1;
          t_addr    = mid;
          state_nxt = S_CHK_MID;
        end else begin
          state_nxt = S_CH0;
        end
      end
      S_CHK_MID: begin
        if (trd_r == tq_r) begin
          exact_nxt = 1'b1;
          hit_nxt   = mid;
          state_nxt = S_CH0;
        end else if (trd_r < tq_r) begin
          lo_nxt    = mid;
          tlo_nxt   = trd_r;
          state_nxt = S_MID;
        end else begin
          hi_nxt    = mid;
          thi_nxt   = trd_r;
          state_nxt = S_MID;
        end
      end
      S_CH0: begin
        ctl.rd_en = 1'b1;
        ctl.addr  = exact_r ? hit_r : lo_r;
        state_nxt = S_CH1;
      end
      S_CH1: begin
        ctl.cap0  = 1'b1;
        ctl.rd_en = 1'b1;
        ctl.addr  = hi_r;
        state_nxt = S_CH2;
      end
      S_CH2: begin
        ctl.start = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (lanes_done && merge_free) begin
          merge_load = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
  assign exact    = exact_r;
  assign outside  = outside_r;

  a_probe_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK_MID |-> hi_r > lo_r)
    else $error("probe outside the search window");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !(exact_r && outside_r))
    else $error("hit and out of range together");
  a_lane_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> !lanes_done)
    else $error("lane done not cleared on start");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    merge_load |=> state_r == S_IDLE)
    else $error("result loaded without return to idle");

endmodule

>>> hw/rtl/sti_merge.sv
// merge stage: gathers lane results and flags into the result register
`timescale 1ns / 1ps
module sti_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic signed [31:0] lane_res [sti_pkg::CHANNELS],
  input  logic               exact,
  input  logic               outside,
  input  logic               out_stall,
  output logic               out_valid,
  output sti_pkg::out_item_t out_item,
  output logic               free
);
  import sti_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t item_r, item_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
    item_r <= item_nxt;
  end

  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (valid_r && !out_stall) valid_nxt = 1'b0;
    if (load) begin
      valid_nxt              = 1'b1;
      item_nxt.vel_east_out  = lane_res[0];
      item_nxt.vel_north_out = lane_res[1];
      item_nxt.vel_down_out  = lane_res[2];
      item_nxt.acc_x_out     = lane_res[3];
      item_nxt.acc_y_out     = lane_res[4];
      item_nxt.acc_z_out     = lane_res[5];
      item_nxt.rate_x_rad    = lane_res[6];
      item_nxt.rate_y_rad    = lane_res[7];
      item_nxt.rate_z_rad    = lane_res[8];
      item_nxt.exact_hit     = exact;
      item_nxt.query_status  = outside;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

>>> hw/rtl/sensor_table_interpolator.sv
// top level of the sensor table interpolator
`timescale 1ns / 1ps
//  channel   ports                                   direction
//  in        in_valid, in_stall, in_item             items in, stall out
//  out       out_valid, out_stall, out_item          results out, stall in
//  cfg       cfg_valid, cfg_ready, cfg_data          entries_in_use write
//
//  a load item is written while the sequencer stays idle; a query runs the sequencer
//  (end checks, one timestamp read per probe with registered read data, two record reads)
//  then the lanes, paced by the 34-step quotient loop and the gyro rounding step,
//  and its result is then loaded into the result register
//  synchronous active-low reset clears control state; the tables are not cleared
//  in_stall is high from query accept until its result enters the output register;
//  out_stall holds the result register and the sequencer waits before reloading it
module sensor_table_interpolator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  sti_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output sti_pkg::out_item_t        out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sti_pkg::CFG_W-1:0] cfg_data
);
  import sti_pkg::*;

  logic [CFG_W-1:0]   entries_r, entries_nxt;
  lane_ctl_t          ctl;
  logic signed [31:0] ch_in    [CHANNELS];
  logic signed [31:0] lane_res [CHANNELS];
  logic [CHANNELS-1:0] lane_done;
  logic merge_load, merge_free, exact, outside;

  // register write is always taken
  assign cfg_ready   = 1'b1;
  assign entries_nxt = (cfg_valid && cfg_ready) ? cfg_data : entries_r;

  always_ff @(posedge clk) begin
    if (!rst_n) entries_r <= CFG_W'(2);
    else        entries_r <= entries_nxt;
  end

  // record channels in lane order
  assign ch_in[0] = in_item.vel_east_in;
  assign ch_in[1] = in_item.vel_north_in;
  assign ch_in[2] = in_item.vel_down_in;
  assign ch_in[3] = in_item.acc_x_in;
  assign ch_in[4] = in_item.acc_y_in;
  assign ch_in[5] = in_item.acc_z_in;
  assign ch_in[6] = in_item.rate_x_deg;
  assign ch_in[7] = in_item.rate_y_deg;
  assign ch_in[8] = in_item.rate_z_deg;

  sti_search u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .entries    (entries_r),
    .lanes_done (&lane_done),
    .merge_free (merge_free),
    .ctl        (ctl),
    .merge_load (merge_load),
    .exact      (exact),
    .outside    (outside)
  );

  // all lanes run in lockstep, gyro lanes add the degree to radian step
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    sti_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .wr_data (ch_in[g]),
      .gyro    (g >= GYRO_FIRST),
      .done    (lane_done[g]),
      .result  (lane_res[g])
    );
  end

  sti_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (merge_load),
    .lane_res  (lane_res),
    .exact     (exact),
    .outside   (outside),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .free      (merge_free)
  );

endmodule
